[design/repeated_byte_vote_decoder_macros.svh]
// Assertion macros shared by the repeated byte vote decoder modules.
// Depends on nothing; each asserting module provides aclk and aresetn.
`ifndef REPEATED_BYTE_VOTE_DECODER_MACROS_SVH
`define REPEATED_BYTE_VOTE_DECODER_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define RBVD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define RBVD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/rbvd_pkg.sv]
// Types and constants of the repeated byte vote decoder.
// Used by rbvd_tally and the top level repeated_byte_vote_decoder.
package rbvd_pkg;

    localparam int VALUE_W     = 8;
    localparam int CFG_W       = 6;
    localparam int WCOUNT_W    = 6;
    localparam int MIN_COUNT_RESET = 6;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_DATA   = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_BELOW_MIN = 2'd3
    } vote_status_t;

    // One received beat.
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic               has_byte;
        logic               last;
    } item_t;

    // One vote result.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        vote_status_t        status;
        logic [WCOUNT_W-1:0] count;
    } result_t;

endpackage

[design/repeated_byte_vote_decoder.sv]
// Top level of the repeated byte vote decoder: stream ports, input and result registers.
// Depends on rbvd_pkg, rbvd_tally and repeated_byte_vote_decoder_macros.svh.
//
// Majority vote over a burst of received bytes that repeat one sent byte. Each input beat
// carries a byte in s_axis_tdata, s_axis_tuser says whether that byte is valid, and
// s_axis_tlast ends the burst. Up to MAX_DISTINCT distinct values are counted, counts
// saturate at MAX_BURST, and one more distinct value marks the burst as overflowed. The
// last beat of a burst yields one result beat with the winner (highest count, first seen
// on a tie), a status and the winner's count; the winner is accepted when its count reaches
// cfg_wr_data as last written (reset value 6). The block takes one beat every cycle unless
// input stalls; a beat is held in the input register while the tally update and the vote run
// through a single compare per tally entry, and the result register then takes the result
// of a last beat. Input stalls only when a result is waiting and a new last beat needs
// the result register.
`include "repeated_byte_vote_decoder_macros.svh"

module repeated_byte_vote_decoder #(
    parameter int MAX_DISTINCT = 3,
    parameter int MAX_BURST    = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: min_valid_count.
    input  logic                        cfg_wr_en,
    input  logic [rbvd_pkg::CFG_W-1:0]  cfg_wr_data,
    // Input channel.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    input  logic                        s_axis_tuser,   // [0] has_byte
    input  logic                        s_axis_tlast,   // burst_end
    // Result channel.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata    // [7:0] decoded_value,
                                                        // [9:8] vote_status,
                                                        // [15:10] winner_count
);
    import rbvd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    item_t             in_item_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg;
    result_t           vote_result;
    logic [CFG_W-1:0]  min_count_reg;
    logic              s_accept;
    logic              advance;
    logic              out_load;
    logic              reject_shown;
    logic              reject_clean;

    // Handshake: the held beat moves on unless it ends a burst and the result slot is busy.
    assign advance       = in_valid_reg &&
                           (!in_item_reg.last || !m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = advance && in_item_reg.last;

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            min_count_reg <= CFG_W'(MIN_COUNT_RESET);
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                min_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data     <= s_axis_tdata;
            in_item_reg.has_byte <= s_axis_tuser;
            in_item_reg.last     <= s_axis_tlast;
        end
        if (out_load) begin
            m_result_reg <= vote_result;
        end
    end

    rbvd_tally #(
        .MAX_DISTINCT (MAX_DISTINCT),
        .MAX_BURST    (MAX_BURST)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (in_item_reg),
        .min_count (min_count_reg),
        .result    (vote_result)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_result_reg.count, m_result_reg.status, m_result_reg.value};

    // A presented rejection must carry neither a value nor a count.
    assign reject_shown = m_valid_reg && ((m_result_reg.status == STATUS_OVERFLOW) ||
                                          (m_result_reg.status == STATUS_NO_DATA));
    assign reject_clean = (m_result_reg.value == '0) && (m_result_reg.count == '0);

    `RBVD_ASSERT(a_stall_only_full, !s_axis_tready |-> in_valid_reg, "input stalled while empty")
    `RBVD_ASSERT(a_load_shows, out_load |=> m_valid_reg, "loaded result not presented")
    `RBVD_ASSERT(a_reject_zero, reject_shown |-> reject_clean, "rejected burst carries data")

endmodule

[design/rbvd_tally.sv]
// Tally of distinct byte values per burst and the vote at the burst end.
// Depends on rbvd_pkg and repeated_byte_vote_decoder_macros.svh.
`include "repeated_byte_vote_decoder_macros.svh"

module rbvd_tally #(
    parameter int MAX_DISTINCT = 3,
    parameter int MAX_BURST    = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  rbvd_pkg::item_t              item,
    input  logic [rbvd_pkg::CFG_W-1:0]   min_count,
    output rbvd_pkg::result_t            result
);
    import rbvd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BURST + 1);
    localparam int USED_W = $clog2(MAX_DISTINCT + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [VALUE_W-1:0] values_reg  [MAX_DISTINCT];
    logic [VALUE_W-1:0] values_next [MAX_DISTINCT];
    logic [CNT_W-1:0]   counts_reg  [MAX_DISTINCT];
    logic [CNT_W-1:0]   counts_next [MAX_DISTINCT];
    logic [USED_W-1:0]  used_reg, used_next;
    logic               overflow_reg, overflow_next;
    logic [MAX_DISTINCT-1:0] hit;
    logic [VALUE_W-1:0] best_value;
    logic [CNT_W-1:0]   best_count;

    // Update the tally with the byte of this beat.
    always_comb begin
        values_next   = values_reg;
        counts_next   = counts_reg;
        used_next     = used_reg;
        overflow_next = overflow_reg;
        for (int k = 0; k < MAX_DISTINCT; k++) begin
            hit[k] = (USED_W'(k) < used_reg) && (values_reg[k] == item.data);
        end
        if (item.has_byte && !overflow_reg) begin
            if (|hit) begin
                for (int k = 0; k < MAX_DISTINCT; k++) begin
                    if (hit[k] && (counts_reg[k] < CNT_W'(MAX_BURST))) begin
                        counts_next[k] = counts_reg[k] + 1'b1;
                    end
                end
            end else if (used_reg < USED_W'(MAX_DISTINCT)) begin
                for (int k = 0; k < MAX_DISTINCT; k++) begin
                    if (used_reg == USED_W'(k)) begin
                        values_next[k] = item.data;
                        counts_next[k] = CNT_W'(1);
                    end
                end
                used_next = used_reg + 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
        end
    end

    // Pick the entry with the highest count; strict compare keeps the first one on a tie.
    always_comb begin
        best_value = '0;
        best_count = '0;
        for (int k = 0; k < MAX_DISTINCT; k++) begin
            if ((USED_W'(k) < used_next) && (counts_next[k] > best_count)) begin
                best_count = counts_next[k];
                best_value = values_next[k];
            end
        end
    end

    // Form the result for a burst end beat.
    always_comb begin
        result.value  = '0;
        result.count  = '0;
        if (overflow_next) begin
            result.status = STATUS_OVERFLOW;
        end else if (used_next == '0) begin
            result.status = STATUS_NO_DATA;
        end else begin
            result.count = WCOUNT_W'(best_count);
            if (CMP_W'(best_count) >= CMP_W'(min_count)) begin
                result.status = STATUS_OK;
                result.value  = best_value;
            end else begin
                result.status = STATUS_BELOW_MIN;
            end
        end
    end

    // Fill count and overflow flag; both clear at the end of each burst.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            overflow_reg <= 1'b0;
        end else if (step_en) begin
            if (item.last) begin
                used_reg     <= '0;
                overflow_reg <= 1'b0;
            end else begin
                used_reg     <= used_next;
                overflow_reg <= overflow_next;
            end
        end
    end

    // Tally entries; only entries below the fill count are ever read.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            values_reg <= values_next;
            counts_reg <= counts_next;
        end
    end

    `RBVD_ASSERT(a_overflow_full, overflow_reg |-> (used_reg == USED_W'(MAX_DISTINCT)), "overflow with free entries")
    `RBVD_ASSERT(a_clear_on_last, (step_en && item.last) |=> ((used_reg == '0) && !overflow_reg), "tally not cleared at burst end")
    `RBVD_ASSERT(a_used_grows, (step_en && !item.last) |=> (used_reg >= $past(used_reg)), "fill count dropped inside a burst")

endmodule
